[src/ssmsd_pkg.sv]
package ssmsd_pkg;

    // Build-time settings of the block
    localparam int MAX_SAMPLES   = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;

    // Field and accumulator widths
    localparam int IN_W   = 16;
    localparam int SUM_W  = 26;
    localparam int SQ_W   = 41;
    localparam int CNT_W  = 11;
    localparam int MEAN_W = 24;
    localparam int DEV_W  = 24;

    // Depth of the queue of closed sets between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Back end arithmetic widths
    localparam int SQ_LO_W = 21;
    localparam int SQ_HI_W = SQ_W - SQ_LO_W;
    localparam int MUL_W   = SUM_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int V_W     = CNT_W + SQ_W;
    localparam int ROOT_W  = V_W / 2 + FRACTION_BITS;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DIV_N_W = SUM_W + FRACTION_BITS + 1;
    localparam int DIV_D_W = CNT_W + 1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [CNT_W-1:0]        cnt;
        logic                    dropped;
    } set_summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_B,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM_A,
        S_DIFF,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_SQRT,
        S_DEV_START,
        S_DEV_WAIT,
        S_FINISH
    } back_state_t;

endpackage

[src/ssmsd_front.sv]
module ssmsd_front
    import ssmsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [IN_W-1:0] sample,
    input  logic                   sample_present,
    input  logic                   last_in_set,
    input  queue_status_t          queue_status,
    output logic                   push,
    output set_summary_t           summary
);

    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQ_W-1:0]               sq_reg, sq_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          drop_reg, drop_next;
    logic signed [SAMPLE_BITS-1:0] sample_sx;
    logic [SAMPLE_BITS-1:0]        sample_mag;
    logic [2*SAMPLE_BITS-1:0]      mag_sq;
    logic                          accept;
    logic                          take;
    logic signed [SUM_W-1:0]       sum_upd;
    logic [SQ_W-1:0]               sq_upd;
    logic [CNT_W-1:0]              cnt_upd;
    logic                          drop_upd;

    assign in_ready = !queue_status.full;
    assign accept   = in_valid && in_ready;

    assign sample_sx  = SAMPLE_BITS'(sample);
    assign sample_mag = sample_sx[SAMPLE_BITS-1] ? (~sample_sx + 1'b1) : sample_sx;
    assign mag_sq     = sample_mag * sample_mag;

    // A present sample only counts while the set still has room.
    assign take = sample_present && (32'(cnt_reg) < 32'(MAX_SAMPLES));

    always_comb
    begin
        sum_upd  = sum_reg;
        sq_upd   = sq_reg;
        cnt_upd  = cnt_reg;
        drop_upd = drop_reg | (sample_present && !take);
        if (take)
        begin
            sum_upd = sum_reg + SUM_W'(sample_sx);
            sq_upd  = sq_reg + SQ_W'(mag_sq);
            cnt_upd = cnt_reg + 1'b1;
        end
    end

    assign push            = accept && last_in_set;
    assign summary.sum     = sum_upd;
    assign summary.sq      = sq_upd;
    assign summary.cnt     = cnt_upd;
    assign summary.dropped = drop_upd;

    always_comb
    begin
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            if (last_in_set)
            begin
                sum_next  = '0;
                sq_next   = '0;
                cnt_next  = '0;
                drop_next = 1'b0;
            end
            else
            begin
                sum_next  = sum_upd;
                sq_next   = sq_upd;
                cnt_next  = cnt_upd;
                drop_next = drop_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

endmodule

[src/ssmsd_queue.sv]
module ssmsd_queue
    import ssmsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  set_summary_t  push_data,
    input  logic          pop,
    output set_summary_t  pop_data,
    output queue_status_t status
);

    set_summary_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/ssmsd_div.sv]
module ssmsd_div
    import ssmsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_N_W + 1);

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [DIV_D_W:0]   rem_shift;
    logic               fits;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of the top of the quotient register as the quotient bits shift in.
    assign rem_shift = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_N_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIV_N_W-2:0], fits};
            rem_next  = fits ? DIV_D_W'(rem_shift - {1'b0, den_reg}) : DIV_D_W'(rem_shift);
            step_next = step_reg - 1'b1;
            busy_next = (step_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[src/ssmsd_back.sv]
module ssmsd_back
    import ssmsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  queue_status_t            queue_status,
    input  set_summary_t             queue_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SUM_W-1:0]  total,
    output logic [CNT_W-1:0]         sample_count,
    output logic signed [MEAN_W-1:0] mean_fixed,
    output logic [DEV_W-1:0]         stddev_fixed,
    output logic                     count_overflow
);

    localparam logic [DIV_N_W-1:0] MEAN_NEG_LIMIT = DIV_N_W'(1) << (MEAN_W - 1);
    localparam logic [DIV_N_W-1:0] MEAN_POS_LIMIT = MEAN_NEG_LIMIT - 1'b1;
    localparam logic [DIV_N_W-1:0] DEV_LIMIT      = (DIV_N_W'(1) << DEV_W) - 1'b1;
    localparam int                 ITER_W         = $clog2(ROOT_W);

    back_state_t        state_reg, state_next;
    set_summary_t       snap_reg;
    logic               neg_reg;
    logic [SUM_W-1:0]   abs_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [V_W-1:0]     a_reg;
    logic [V_W-1:0]     b_reg;
    logic [V_W-1:0]     v_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]  total_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [MEAN_W-1:0] mean_out_reg;
    logic [DEV_W-1:0]         dev_out_reg;
    logic                     ovf_reg;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_busy;
    logic [DIV_N_W-1:0] div_quotient;
    logic               out_load;
    logic               out_free;
    logic               queue_sum_neg;
    logic [SUM_W-1:0]   queue_sum_abs;
    logic [REM_W+1:0]   rem_shift;
    logic [REM_W-1:0]   trial;
    logic               root_bit;
    logic [DIV_N_W-1:0] mean_mag;
    logic [DEV_W-1:0]   dev_sat;

    ssmsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign out_free      = !out_valid_reg || out_ready;
    assign queue_sum_neg = queue_data.sum[SUM_W-1];
    assign queue_sum_abs = queue_sum_neg ? SUM_W'(-queue_data.sum) : SUM_W'(queue_data.sum);

    assign mul_prod = mul_a * mul_b;

    // One step of the bit-pair square root.
    assign rem_shift = {rem_reg, v_reg[V_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign root_bit  = (rem_shift >= (REM_W + 2)'(trial));

    always_comb
    begin
        if (neg_reg)
        begin
            mean_mag = (div_quotient > MEAN_NEG_LIMIT) ? MEAN_NEG_LIMIT : div_quotient;
        end
        else
        begin
            mean_mag = (div_quotient > MEAN_POS_LIMIT) ? MEAN_POS_LIMIT : div_quotient;
        end
        dev_sat = (div_quotient > DEV_LIMIT) ? DEV_W'(DEV_LIMIT) : DEV_W'(div_quotient);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_status.empty)
                begin
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B:
            begin
                state_next = (snap_reg.cnt == '0) ? S_FINISH : S_MUL_LO;
            end
            S_MUL_LO:     state_next = S_MUL_HI;
            S_MUL_HI:     state_next = S_SUM_A;
            S_SUM_A:      state_next = S_DIFF;
            S_DIFF:       state_next = S_MEAN_START;
            S_MEAN_START: state_next = S_MEAN_WAIT;
            S_MEAN_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    state_next = S_DEV_START;
                end
            end
            S_DEV_START:  state_next = S_DEV_WAIT;
            S_DEV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_N_W'(root_reg);
        div_divisor  = DIV_D_W'(snap_reg.cnt);
        mul_a        = abs_reg;
        mul_b        = abs_reg;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE:       pop = !queue_status.empty;
            S_MUL_LO:
            begin
                mul_a = MUL_W'(snap_reg.cnt);
                mul_b = MUL_W'(snap_reg.sq[SQ_LO_W-1:0]);
            end
            S_MUL_HI:
            begin
                mul_a = MUL_W'(snap_reg.cnt);
                mul_b = MUL_W'(snap_reg.sq[SQ_W-1:SQ_LO_W]);
            end
            S_MEAN_START:
            begin
                div_start    = 1'b1;
                div_dividend = (DIV_N_W'(abs_reg) << (FRACTION_BITS + 1)) + DIV_N_W'(snap_reg.cnt);
                div_divisor  = {snap_reg.cnt, 1'b0};
            end
            S_DEV_START:  div_start = 1'b1;
            S_FINISH:     out_load = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                snap_reg <= queue_data;
                neg_reg  <= queue_sum_neg;
                abs_reg  <= queue_sum_abs;
            end
            S_MUL_B:
            begin
                prod_reg <= mul_prod;
                mean_reg <= '0;
                dev_reg  <= '0;
            end
            S_MUL_LO:
            begin
                b_reg    <= V_W'(prod_reg);
                prod_reg <= mul_prod;
            end
            S_MUL_HI:
            begin
                a_reg    <= V_W'(prod_reg);
                prod_reg <= mul_prod;
            end
            S_SUM_A:
            begin
                a_reg <= a_reg + (V_W'(prod_reg) << SQ_LO_W);
            end
            S_DIFF:
            begin
                // A variance term that is not positive gives a deviation of zero.
                v_reg <= (a_reg > b_reg) ? (a_reg - b_reg) : '0;
            end
            S_MEAN_WAIT:
            begin
                mean_reg <= neg_reg ? MEAN_W'(-mean_mag) : MEAN_W'(mean_mag);
                root_reg <= '0;
                rem_reg  <= '0;
                iter_reg <= '0;
            end
            S_SQRT:
            begin
                rem_reg  <= root_bit ? REM_W'(rem_shift - (REM_W + 2)'(trial))
                                     : REM_W'(rem_shift);
                root_reg <= {root_reg[ROOT_W-2:0], root_bit};
                v_reg    <= v_reg << 2;
                iter_reg <= iter_reg + 1'b1;
            end
            S_DEV_WAIT:
            begin
                dev_reg <= dev_sat;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            total_reg    <= snap_reg.sum;
            count_reg    <= snap_reg.cnt;
            mean_out_reg <= mean_reg;
            dev_out_reg  <= dev_reg;
            ovf_reg      <= snap_reg.dropped;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign total          = total_reg;
    assign sample_count   = count_reg;
    assign mean_fixed     = mean_out_reg;
    assign stddev_fixed   = dev_out_reg;
    assign count_overflow = ovf_reg;

endmodule

[src/sample_set_mean_and_stddev_top.sv]
// Running mean and population standard deviation of a set of signed samples.
// Samples are taken at one per clock cycle while in_ready is high; each is
// added into a running sum, sum of squares and count, and a transaction with
// last_in_set high closes the set. A closed set then passes through a
// two-entry queue to a sequential back end that forms n*S2 - S1^2 on a shared
// 26x26 multiplier, divides for the rounded mean, takes the square root one
// bit pair per cycle and divides again for the deviation, with 35-step
// divisions and a 34-step root at the default sizes. The sample side only
// stalls when two closed sets are already waiting. An empty set gives zeros,
// and samples past the maximum count are dropped and flagged.
module sample_set_mean_and_stddev_top
    import ssmsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [IN_W-1:0]   sample,
    input  logic                     sample_present,
    input  logic                     last_in_set,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SUM_W-1:0]  total,
    output logic [CNT_W-1:0]         sample_count,
    output logic signed [MEAN_W-1:0] mean_fixed,
    output logic [DEV_W-1:0]         stddev_fixed,
    output logic                     count_overflow
);

    queue_status_t queue_status;
    set_summary_t  push_data;
    set_summary_t  pop_data;
    logic          push;
    logic          pop;

    ssmsd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .sample_present (sample_present),
        .last_in_set    (last_in_set),
        .queue_status   (queue_status),
        .push           (push),
        .summary        (push_data)
    );

    ssmsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (queue_status)
    );

    ssmsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_status   (queue_status),
        .queue_data     (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total          (total),
        .sample_count   (sample_count),
        .mean_fixed     (mean_fixed),
        .stddev_fixed   (stddev_fixed),
        .count_overflow (count_overflow)
    );

endmodule
